// ===== rtl/cipd_pkg.sv =====
// Package for the channel id pool and demultiplexer.
// Holds sizes, function and result codes and state types; depends on nothing.
`timescale 1ns / 1ps

package cipd_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int POOL_DEPTH  = 16;
  localparam int LIVE_IDS    = (MAX_CLIENTS > POOL_DEPTH) ? POOL_DEPTH :
                               ((MAX_CLIENTS < 1) ? 1 : MAX_CLIENTS);
  localparam int POOL_AW     = $clog2(POOL_DEPTH);
  localparam int COUNT_W     = POOL_AW + 1;
  localparam int ID_W        = 8;

  localparam logic [2:0] FUNC_BYTE       = 3'd0;
  localparam logic [2:0] FUNC_CONNECT    = 3'd1;
  localparam logic [2:0] FUNC_DISCONNECT = 3'd2;
  localparam logic [2:0] FUNC_UP         = 3'd3;
  localparam logic [2:0] FUNC_DOWN       = 3'd4;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REFUSE  = 2'd2;
  localparam logic [1:0] KIND_SHUT    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_CONN,
    ST_SHUT
  } state_t;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_ID_LO,
    PH_ID_HI,
    PH_DATA
  } phase_t;

endpackage

// ===== rtl/cipd_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module cipd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/channel_id_pool_and_demux.sv =====
// Top level of the channel id pool and backend stream demultiplexer.
// Depends on cipd_pkg and cipd_ram.
`timescale 1ns / 1ps

// Usage.
// The input channel (in_valid, in_stall) carries one command per transfer:
// a backend stream byte, a client connect or disconnect, backend up or
// backend down. The output channel (out_valid, out_stall) carries results:
// tagged payload bytes, connect accepted or refused, and shut orders.
// run_last marks the final result of a command.
// A stream byte or a disconnect is taken every cycle while the output
// register can take a transfer; a payload result is loaded into the output register in the cycle after.
// A connect with ids left in the pool moves to ST_CONN, which loads the id read
// from the pool memory as the result and takes no command; an empty pool gives a refuse result.
// Backend up, while the backend is down, writes the ids into the pool memory,
// one per cycle, and takes no command until all LIVE_IDS ids are written.
// Backend down walks the open map one id per cycle up to the highest open id,
// one result per open id; it holds at an open id while the output is stalled.
// Reset clears the open map, the pool pointers and the parser; the pool
// memory contents are left as they are. When the receiver stalls, the
// result is held in the output register and no further command is taken.
module channel_id_pool_and_demux (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            func,
  input  logic [7:0]            stream_byte,
  input  logic [cipd_pkg::ID_W-1:0] leaving_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [cipd_pkg::ID_W-1:0] channel,
  output logic [7:0]            payload,
  output logic                  frame_end,
  output logic                  run_last
);

  import cipd_pkg::*;

  state_t                  state, state_next;
  phase_t                  phase, phase_next;
  logic [POOL_AW-1:0]      head, head_next;
  logic [POOL_AW-1:0]      tail, tail_next;
  logic [COUNT_W-1:0]      count, count_next;
  logic [POOL_DEPTH-1:0]   open_map, open_map_next;
  logic                    alive, alive_next;
  logic [7:0]              bytes_left, bytes_left_next;
  logic [15:0]             frame_channel, frame_channel_next;
  logic [POOL_AW-1:0]      scan_idx, scan_idx_next;

  logic                    out_free;
  logic                    in_accept;
  logic                    out_load;
  logic [1:0]              o_kind;
  logic [ID_W-1:0]         o_channel;
  logic [7:0]              o_payload;
  logic                    o_frame_end;
  logic                    o_run_last;

  logic                    ram_we;
  logic [POOL_AW-1:0]      ram_waddr;
  logic [ID_W-1:0]         ram_wdata;
  logic [ID_W-1:0]         ram_rdata;

  cipd_ram #(
    .WIDTH (ID_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == ST_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    logic [POOL_DEPTH-1:0] scan_sel;
    logic [POOL_DEPTH-1:0] map_left;
    logic                  chan_open;
    logic                  leave_open;
    logic                  id_ok;

    scan_sel   = POOL_DEPTH'(1) << scan_idx;
    map_left   = open_map & ~scan_sel;
    chan_open  = (frame_channel != 16'd0) && (frame_channel <= 16'(LIVE_IDS)) &&
                 open_map[POOL_AW'(frame_channel - 16'd1)];
    leave_open = (leaving_id != '0) && (leaving_id <= ID_W'(LIVE_IDS)) &&
                 open_map[POOL_AW'(leaving_id - ID_W'(1))];
    id_ok      = (ram_rdata != '0) && (ram_rdata <= ID_W'(LIVE_IDS));

    state_next         = state;
    phase_next         = phase;
    head_next          = head;
    tail_next          = tail;
    count_next         = count;
    open_map_next      = open_map;
    alive_next         = alive;
    bytes_left_next    = bytes_left;
    frame_channel_next = frame_channel;
    scan_idx_next      = scan_idx;

    out_load    = 1'b0;
    o_kind      = KIND_PAYLOAD;
    o_channel   = '0;
    o_payload   = '0;
    o_frame_end = 1'b0;
    o_run_last  = 1'b1;

    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = leaving_id;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (func)
            FUNC_BYTE: begin
              if (alive) begin
                case (phase)
                  PH_LEN: begin
                    bytes_left_next = stream_byte;
                    phase_next      = PH_ID_LO;
                  end
                  PH_ID_LO: begin
                    frame_channel_next = {8'd0, stream_byte};
                    phase_next         = PH_ID_HI;
                  end
                  PH_ID_HI: begin
                    frame_channel_next = {stream_byte, frame_channel[7:0]};
                    phase_next         = (bytes_left == 8'd0) ? PH_LEN : PH_DATA;
                  end
                  default: begin
                    if (chan_open) begin
                      out_load    = 1'b1;
                      o_kind      = KIND_PAYLOAD;
                      o_channel   = frame_channel[ID_W-1:0];
                      o_payload   = stream_byte;
                      o_frame_end = (bytes_left == 8'd1);
                    end
                    bytes_left_next = bytes_left - 8'd1;
                    if (bytes_left == 8'd1) begin
                      phase_next = PH_LEN;
                    end
                  end
                endcase
              end
            end
            FUNC_CONNECT: begin
              if (count != '0) begin
                state_next = ST_CONN;
              end else begin
                out_load = 1'b1;
                o_kind   = KIND_REFUSE;
              end
            end
            FUNC_DISCONNECT: begin
              if (alive && leave_open) begin
                open_map_next[POOL_AW'(leaving_id - ID_W'(1))] = 1'b0;
                if (count < COUNT_W'(POOL_DEPTH)) begin
                  ram_we     = 1'b1;
                  tail_next  = tail + POOL_AW'(1);
                  count_next = count + COUNT_W'(1);
                end
              end
            end
            FUNC_UP: begin
              if (!alive) begin
                alive_next    = 1'b1;
                head_next     = '0;
                tail_next     = '0;
                count_next    = '0;
                scan_idx_next = '0;
                state_next    = ST_FILL;
              end
            end
            FUNC_DOWN: begin
              alive_next         = 1'b0;
              head_next          = '0;
              tail_next          = '0;
              count_next         = '0;
              phase_next         = PH_LEN;
              bytes_left_next    = '0;
              frame_channel_next = '0;
              scan_idx_next      = '0;
              if (open_map != '0) begin
                state_next = ST_SHUT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        ram_we        = 1'b1;
        ram_waddr     = scan_idx;
        ram_wdata     = ID_W'(scan_idx) + ID_W'(1);
        tail_next     = scan_idx + POOL_AW'(1);
        count_next    = COUNT_W'(scan_idx) + COUNT_W'(1);
        scan_idx_next = scan_idx + POOL_AW'(1);
        if (scan_idx == POOL_AW'(LIVE_IDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_CONN: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_kind     = KIND_ACCEPT;
          o_channel  = ram_rdata;
          head_next  = head + POOL_AW'(1);
          count_next = count - COUNT_W'(1);
          if (id_ok) begin
            open_map_next[POOL_AW'(ram_rdata - ID_W'(1))] = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_SHUT: begin
        if (open_map[scan_idx]) begin
          if (out_free) begin
            out_load      = 1'b1;
            o_kind        = KIND_SHUT;
            o_channel     = ID_W'(scan_idx) + ID_W'(1);
            o_run_last    = (map_left == '0);
            open_map_next = map_left;
            scan_idx_next = scan_idx + POOL_AW'(1);
            if (map_left == '0) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          scan_idx_next = scan_idx + POOL_AW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_LEN;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      open_map      <= '0;
      alive         <= 1'b0;
      bytes_left    <= '0;
      frame_channel <= '0;
      scan_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      head          <= head_next;
      tail          <= tail_next;
      count         <= count_next;
      open_map      <= open_map_next;
      alive         <= alive_next;
      bytes_left    <= bytes_left_next;
      frame_channel <= frame_channel_next;
      scan_idx      <= scan_idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind      <= o_kind;
      channel   <= o_channel;
      payload   <= o_payload;
      frame_end <= o_frame_end;
      run_last  <= o_run_last;
    end
  end

endmodule

// ===== rtl/cipd_checker.sv =====
// Port-level checks for the channel id pool and demultiplexer, bound to the top level.
// Depends on cipd_pkg.
`timescale 1ns / 1ps

module cipd_port_props (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [2:0]            func,
  input logic [7:0]            stream_byte,
  input logic [cipd_pkg::ID_W-1:0] leaving_id,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            kind,
  input logic [cipd_pkg::ID_W-1:0] channel,
  input logic [7:0]            payload,
  input logic                  frame_end,
  input logic                  run_last
);

  import cipd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result pending after reset.");

  a_refuse_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REFUSE) |-> (channel == '0) && run_last)
    else $error("Refused connect carries a channel or is not last.");

  a_non_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_PAYLOAD) |-> (payload == '0) && !frame_end)
    else $error("Non-payload result carries payload bits.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(channel) &&
    $stable(payload) && $stable(run_last))
    else $error("Stalled result changed.");

endmodule

bind channel_id_pool_and_demux cipd_port_props u_cipd_port_props (.*);

// ===== tb/sv/cipd_checker.sv =====
// Checker for the channel id pool and demultiplexer: watches both channels,
// predicts the results of every accepted command and compares them in order.
// Depends on cipd_pkg for sizes, function codes, result codes and parser phases.
`timescale 1ns / 1ps

module cipd_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [2:0]                func,
  input  logic [7:0]                stream_byte,
  input  logic [cipd_pkg::ID_W-1:0] leaving_id,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                kind,
  input  logic [cipd_pkg::ID_W-1:0] channel,
  input  logic [7:0]                payload,
  input  logic                      frame_end,
  input  logic                      run_last,
  output int                        fails,
  output int                        pending
);

  import cipd_pkg::*;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] channel;
    logic [7:0]      payload;
    logic            frame_end;
    logic            run_last;
  } result_t;

  result_t due_results[$];

  logic [ID_W-1:0]       id_fifo [POOL_DEPTH];
  logic [POOL_AW-1:0]    fifo_head;
  logic [POOL_AW-1:0]    fifo_tail;
  logic [COUNT_W-1:0]    fifo_fill;
  logic [POOL_DEPTH-1:0] open_ids;
  logic                  link_alive;
  phase_t                phase;
  logic [7:0]            frame_left;
  logic [15:0]           frame_id;

  initial begin
    fails   = 0;
    pending = 0;
  end

  task automatic step_pool_and_parser(input logic [2:0] f, input logic [7:0] sb,
                                      input logic [ID_W-1:0] lid);
    result_t batch[$];
    result_t r;
    int      id;
    r = '0;
    case (f)
      FUNC_BYTE: begin
        if (link_alive) begin
          case (phase)
            PH_LEN: begin
              frame_left = sb;
              phase = PH_ID_LO;
            end
            PH_ID_LO: begin
              frame_id = {8'd0, sb};
              phase = PH_ID_HI;
            end
            PH_ID_HI: begin
              frame_id[15:8] = sb;
              phase = (frame_left == 8'd0) ? PH_LEN : PH_DATA;
            end
            default: begin
              id = int'(frame_id);
              if (id >= 1 && id <= LIVE_IDS && open_ids[POOL_AW'(id-1)]) begin
                r.kind = KIND_PAYLOAD;
                r.channel = frame_id[ID_W-1:0];
                r.payload = sb;
                r.frame_end = (frame_left == 8'd1);
                batch = {batch, r};
              end
              frame_left = frame_left - 8'd1;
              if (frame_left == 8'd0) phase = PH_LEN;
            end
          endcase
        end
      end
      FUNC_CONNECT: begin
        if (fifo_fill != '0) begin
          id = int'(id_fifo[fifo_head]);
          fifo_head = fifo_head + 1'b1;
          fifo_fill = fifo_fill - 1'b1;
          if (id >= 1 && id <= LIVE_IDS) open_ids[POOL_AW'(id-1)] = 1'b1;
          r.kind = KIND_ACCEPT;
          r.channel = ID_W'(id);
        end else begin
          r.kind = KIND_REFUSE;
        end
        batch = {batch, r};
      end
      FUNC_DISCONNECT: begin
        id = int'(lid);
        if (link_alive && id >= 1 && id <= LIVE_IDS && open_ids[POOL_AW'(id-1)]) begin
          open_ids[POOL_AW'(id-1)] = 1'b0;
          if (fifo_fill < POOL_DEPTH) begin
            id_fifo[fifo_tail] = lid;
            fifo_tail = fifo_tail + 1'b1;
            fifo_fill = fifo_fill + 1'b1;
          end
        end
      end
      FUNC_UP: begin
        if (!link_alive) begin
          link_alive = 1'b1;
          fifo_head = '0;
          fifo_tail = '0;
          fifo_fill = '0;
          for (int i = 1; i <= LIVE_IDS; i++) begin
            id_fifo[fifo_tail] = ID_W'(i);
            fifo_tail = fifo_tail + 1'b1;
            fifo_fill = fifo_fill + 1'b1;
          end
        end
      end
      FUNC_DOWN: begin
        link_alive = 1'b0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
          if (open_ids[POOL_AW'(i)]) begin
            r.kind = KIND_SHUT;
            r.channel = ID_W'(i + 1);
            batch = {batch, r};
          end
        end
        open_ids = '0;
        fifo_head = '0;
        fifo_tail = '0;
        fifo_fill = '0;
        phase = PH_LEN;
        frame_left = '0;
        frame_id = '0;
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
    due_results = {due_results, batch};
  endtask

  task automatic check_field(input string name, input int want, input int got,
                             inout bit bad);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    bit      bad;
    if (rst) begin
      open_ids = '0;
      fifo_head = '0;
      fifo_tail = '0;
      fifo_fill = '0;
      link_alive = 1'b0;
      phase = PH_LEN;
      frame_left = '0;
      frame_id = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual kind %0d channel %0d",
                   $time, kind, channel);
          fails++;
        end else begin
          want = due_results.pop_front();
          bad = 1'b0;
          check_field("kind", int'(want.kind), int'(kind), bad);
          check_field("channel", int'(want.channel), int'(channel), bad);
          check_field("payload", int'(want.payload), int'(payload), bad);
          check_field("frame_end", int'(want.frame_end), int'(frame_end), bad);
          check_field("run_last", int'(want.run_last), int'(run_last), bad);
          if (bad) fails++;
        end
      end
      if (in_valid && !in_stall) step_pool_and_parser(func, stream_byte, leaving_id);
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the testbench: clock, reset, command stimulus and the verdict.
// Depends on cipd_pkg, the block channel_id_pool_and_demux and cipd_checker.
`timescale 1ns / 1ps

module tb;
  import cipd_pkg::*;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic [2:0]      func = FUNC_BYTE;
  logic [7:0]      stream_byte = '0;
  logic [ID_W-1:0] leaving_id = '0;
  logic            out_stall = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic [1:0]      kind;
  logic [ID_W-1:0] channel;
  logic [7:0]      payload;
  logic            frame_end;
  logic            run_last;
  logic            quiet = 1'b0;
  int              fails;
  int              pending;

  channel_id_pool_and_demux u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .stream_byte(stream_byte), .leaving_id(leaving_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .channel(channel), .payload(payload),
    .frame_end(frame_end), .run_last(run_last)
  );

  cipd_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .stream_byte(stream_byte), .leaving_id(leaving_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .channel(channel), .payload(payload),
    .frame_end(frame_end), .run_last(run_last),
    .fails(fails), .pending(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 30);
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one command and returns once its transfer has taken place.
  task automatic send_cmd(input logic [2:0] f, input logic [7:0] sb,
                          input logic [ID_W-1:0] lid);
    while (!quiet && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    stream_byte <= sb;
    leaving_id <= lid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int          sent;
    int          pick;
    int          len;
    logic [7:0]  frame_q[$];
    bit          link_up;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(FUNC_CONNECT, 8'h00, 8'h00);
    send_cmd(FUNC_BYTE, 8'hFF, 8'hFF);
    send_cmd(FUNC_DISCONNECT, 8'h00, 8'd1);
    send_cmd(3'd5, 8'hFF, 8'hFF);
    send_cmd(3'd6, 8'h00, 8'h00);
    send_cmd(3'd7, 8'hFF, 8'hFF);
    send_cmd(FUNC_UP, 8'h00, 8'h00);
    send_cmd(FUNC_UP, 8'h00, 8'h00);
    send_cmd(FUNC_CONNECT, 8'h00, 8'h00);
    send_cmd(FUNC_CONNECT, 8'h00, 8'h00);
    send_cmd(FUNC_BYTE, 8'd2, 8'h00);
    send_cmd(FUNC_BYTE, 8'd1, 8'h00);
    send_cmd(FUNC_BYTE, 8'd0, 8'h00);
    send_cmd(FUNC_BYTE, 8'h00, 8'h00);
    send_cmd(FUNC_BYTE, 8'hFF, 8'h00);
    send_cmd(FUNC_BYTE, 8'd0, 8'h00);
    send_cmd(FUNC_BYTE, 8'd2, 8'h00);
    send_cmd(FUNC_BYTE, 8'd0, 8'h00);
    send_cmd(FUNC_BYTE, 8'd1, 8'h00);
    send_cmd(FUNC_BYTE, 8'd1, 8'h00);
    send_cmd(FUNC_BYTE, 8'hFF, 8'h00);
    send_cmd(FUNC_BYTE, 8'hAA, 8'h00);
    send_cmd(FUNC_DISCONNECT, 8'h00, 8'd0);
    send_cmd(FUNC_DISCONNECT, 8'h00, 8'd255);
    send_cmd(FUNC_DISCONNECT, 8'h00, 8'd2);
    send_cmd(FUNC_DISCONNECT, 8'h00, 8'd2);
    send_cmd(FUNC_DOWN, 8'h00, 8'h00);

    // Mostly well-formed frames to ids that are likely to be open, interleaved
    // with connects, disconnects and the odd link restart or stray byte.
    sent = 0;
    link_up = 1'b0;
    while (sent < 150) begin
      quiet <= (sent >= 50 && sent < 100);
      pick = $urandom_range(0, 99);
      if (!link_up && pick < 60) begin
        send_cmd(FUNC_UP, any_byte(), any_byte());
        link_up = 1'b1;
        sent++;
      end else if (frame_q.size() > 0 && pick < 70) begin
        send_cmd(FUNC_BYTE, frame_q.pop_front(), any_byte());
        if (link_up) sent++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          send_cmd(FUNC_CONNECT, any_byte(), any_byte());
          sent++;
        end else if (pick < 50) begin
          send_cmd(FUNC_DISCONNECT, any_byte(),
                   ($urandom_range(0, 9) == 0) ? any_byte()
                                               : 8'($urandom_range(1, LIVE_IDS)));
          sent++;
        end else if (pick < 80) begin
          if (frame_q.size() == 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                              : $urandom_range(0, 6);
            frame_q = {frame_q, 8'(len)};
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
              frame_q = {frame_q, 8'($urandom_range(1, LIVE_IDS))};
              frame_q = {frame_q, 8'h00};
            end else if (pick < 90) begin
              frame_q = {frame_q, any_byte()};
              frame_q = {frame_q, 8'h00};
            end else begin
              frame_q = {frame_q, any_byte()};
              frame_q = {frame_q, any_byte()};
            end
            repeat (len) frame_q = {frame_q, any_byte()};
          end
        end else if (pick < 85) begin
          send_cmd(FUNC_BYTE, any_byte(), any_byte());
          if (link_up) sent++;
        end else if (pick < 90) begin
          send_cmd(FUNC_UP, any_byte(), any_byte());
          link_up = 1'b1;
          sent++;
        end else if (pick < 95) begin
          send_cmd(FUNC_DOWN, any_byte(), any_byte());
          link_up = 1'b0;
          frame_q.delete();
          sent++;
        end else begin
          send_cmd(3'($urandom_range(5, 7)), any_byte(), any_byte());
        end
      end
    end
    in_valid <= 1'b0;
    quiet <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cipd_pkg.sv
rtl/cipd_ram.sv
rtl/channel_id_pool_and_demux.sv
rtl/cipd_checker.sv
tb/sv/cipd_checker.sv
tb/sv/tb.sv
